### rtl/core/stxlsf_pkg.sv
// Shared types and codes for the length/sum frame receiver.
package stxlsf_pkg;

   localparam int unsigned BYTE_W = 8;

   typedef enum logic [1:0] {
      KIND_INFO   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_START_BYTE = 1'b0,
      CSR_NAK_BYTE   = 1'b1
   } csr_index_type;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd2;
   localparam logic [BYTE_W-1:0] NAK_BYTE_RESET   = 8'd85;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] byte_index;
      logic [BYTE_W-1:0] data_value;
   } result_type;

endpackage

### rtl/core/stx_length_sum_frame_receiver_core.sv
// Top level of the start/length framed receiver with 8-bit additive check.
//
// Usage:
//   req_* carries one received byte per request (valid/ready). Each request
//   is decoded in the cycle it is accepted and its result, if any, is loaded
//   into the rsp_* output register: kind info (byte and its position),
//   accept (command byte) or reject (NAK byte).
//   A result appears on rsp_* in the cycle after its request is accepted.
//   Throughput: one request per cycle, set by the single output register;
//   req_ready stays high while the output register is empty or being drained
//   in the same cycle.
//   Stall: when rsp_ready is low with a result waiting, req_ready drops and
//   the frame state holds until the result is taken.
//   Reset (synchronous, active high): parser returns to idle, start byte 2,
//   NAK byte 85, output register empty.
//   csr_*: write start byte (index 0) or NAK byte (index 1) while idle.
module stx_length_sum_frame_receiver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte_index,
   output logic [7:0]  rsp_data_value
);

   stxlsf_pkg::result_type result;
   stxlsf_pkg::result_type rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   stxlsf_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step_valid       (step),
      .rx_byte          (req_rx_byte),
      .result           (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step && result.valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_byte_index = rsp_ff.byte_index;
   assign rsp_data_value = rsp_ff.data_value;

   // a decoded result is always loaded
   assert property (@(posedge clock) disable iff (reset)
      step && result.valid |=> rsp_valid_ff)
      else $error("result lost");

   // a result that is not taken blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request accepted over a stalled result");

   // a taken result with nothing new leaves the register empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !(step && result.valid) |=> !rsp_valid_ff)
      else $error("result repeated");

endmodule

### rtl/core/stxlsf_parser.sv
// Frame parser: control registers, frame state and per-byte result decode.
module stxlsf_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic                             csr_index,
   input  logic [stxlsf_pkg::BYTE_W-1:0]    csr_write_data,
   input  logic                             step_valid,
   input  logic [stxlsf_pkg::BYTE_W-1:0]    rx_byte,
   output stxlsf_pkg::result_type           result
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [stxlsf_pkg::BYTE_W-1:0]   start_byte_ff, nak_byte_ff;
   logic [stxlsf_pkg::BYTE_W-1:0]   frame_length_ff, frame_length_in;
   logic [stxlsf_pkg::BYTE_W-1:0]   position_ff, position_in;
   logic [stxlsf_pkg::BYTE_W-1:0]   running_sum_ff, running_sum_in;
   logic [stxlsf_pkg::BYTE_W-1:0]   command_byte_ff, command_byte_in;
   logic [stxlsf_pkg::BYTE_W:0]     next_position;
   logic                            body_more;
   logic                            first_info;

   assign next_position = {1'b0, position_ff} + {{stxlsf_pkg::BYTE_W{1'b0}}, 1'b1};
   assign body_more     = next_position < {1'b0, frame_length_ff};
   assign first_info    = position_ff == {{(stxlsf_pkg::BYTE_W-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      position_in     = position_ff;
      running_sum_in  = running_sum_ff;
      command_byte_in = command_byte_ff;
      result          = '0;
      result.kind     = stxlsf_pkg::KIND_INFO;
      if (step_valid) begin
         case (phase_ff)
            PH_LEN: begin
               if (rx_byte < stxlsf_pkg::BYTE_W'(2)) begin
                  phase_in          = PH_IDLE;
                  result.valid      = 1'b1;
                  result.kind       = stxlsf_pkg::KIND_REJECT;
                  result.data_value = nak_byte_ff;
               end else begin
                  frame_length_in = rx_byte;
                  running_sum_in  = rx_byte;
                  position_in     = stxlsf_pkg::BYTE_W'(1);
                  command_byte_in = '0;
                  phase_in        = PH_BODY;
               end
            end
            PH_BODY: begin
               if (first_info) begin
                  command_byte_in = rx_byte;
               end
               result.valid = 1'b1;
               if (body_more) begin
                  running_sum_in    = running_sum_ff + rx_byte;
                  position_in       = next_position[stxlsf_pkg::BYTE_W-1:0];
                  result.kind       = stxlsf_pkg::KIND_INFO;
                  result.byte_index = position_ff;
                  result.data_value = rx_byte;
               end else begin
                  phase_in = PH_IDLE;
                  if (rx_byte == running_sum_ff) begin
                     result.kind       = stxlsf_pkg::KIND_ACCEPT;
                     result.data_value = first_info ? rx_byte : command_byte_ff;
                  end else begin
                     result.kind       = stxlsf_pkg::KIND_REJECT;
                     result.data_value = nak_byte_ff;
                  end
               end
            end
            default: begin
               phase_in = (rx_byte == start_byte_ff) ? PH_LEN : PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         start_byte_ff   <= stxlsf_pkg::START_BYTE_RESET;
         nak_byte_ff     <= stxlsf_pkg::NAK_BYTE_RESET;
         frame_length_ff <= '0;
         position_ff     <= '0;
         running_sum_ff  <= '0;
         command_byte_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         position_ff     <= position_in;
         running_sum_ff  <= running_sum_in;
         command_byte_ff <= command_byte_in;
         if (csr_write_enable) begin
            case (stxlsf_pkg::csr_index_type'(csr_index))
               stxlsf_pkg::CSR_START_BYTE: start_byte_ff <= csr_write_data;
               stxlsf_pkg::CSR_NAK_BYTE:   nak_byte_ff   <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // end of a frame always drops back to idle
   assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.kind == stxlsf_pkg::KIND_ACCEPT ||
                       result.kind == stxlsf_pkg::KIND_REJECT)
      |=> phase_ff == PH_IDLE)
      else $error("verdict not followed by idle");

   // inside a frame the position stays short of the length
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> position_ff != '0 && position_ff < frame_length_ff)
      else $error("frame position out of range");

   // a length byte of two or more opens the body with the sum seeded
   assert property (@(posedge clock) disable iff (reset)
      step_valid && phase_ff == PH_LEN && !result.valid
      |=> phase_ff == PH_BODY && running_sum_ff == frame_length_ff)
      else $error("body not opened after length byte");

   // no result from an idle byte
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_LEN && phase_ff != PH_BODY |-> !result.valid)
      else $error("result while idle");

endmodule

### verif/frame_result_checker.sv
// Watches the frame receiver ports, predicts each response and compares it in order.
module frame_result_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  stxlsf_pkg::csr_index_type csr_index,
   input  logic [7:0]                csr_write_data,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [1:0]                rsp_kind,
   input  logic [7:0]                rsp_byte_index,
   input  logic [7:0]                rsp_data_value,
   input  logic                      end_of_test,
   output int                        fault_count,
   output int                        result_backlog,
   output int                        results_checked,
   output logic                      frame_open
);

   typedef enum logic [1:0] {
      LINK_IDLE   = 2'd0,
      LINK_LENGTH = 2'd1,
      LINK_BODY   = 2'd2
   } link_state_type;

   link_state_type         link_state = LINK_IDLE;
   logic [7:0]             open_byte  = stxlsf_pkg::START_BYTE_RESET;
   logic [7:0]             nak_value  = stxlsf_pkg::NAK_BYTE_RESET;
   logic [7:0]             frame_len  = '0;
   logic [7:0]             frame_pos  = '0;
   logic [7:0]             frame_sum  = '0;
   logic [7:0]             frame_cmd  = '0;
   logic                   leftovers_reported = 1'b0;
   stxlsf_pkg::result_type expected_results [$];

   initial begin
      fault_count     = 0;
      result_backlog  = 0;
      results_checked = 0;
      frame_open      = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fault_count++;
   endtask

   function automatic stxlsf_pkg::result_type decode_rx_byte(input logic [7:0] rx);
      stxlsf_pkg::result_type outcome;
      outcome = '{1'b0, stxlsf_pkg::KIND_INFO, 8'd0, 8'd0};
      case (link_state)
         LINK_LENGTH: begin
            if (rx < 8'd2) begin
               link_state = LINK_IDLE;
               outcome    = '{1'b1, stxlsf_pkg::KIND_REJECT, 8'd0, nak_value};
            end else begin
               frame_len  = rx;
               frame_sum  = rx;
               frame_pos  = 8'd1;
               frame_cmd  = 8'd0;
               link_state = LINK_BODY;
            end
         end
         LINK_BODY: begin
            if (frame_pos == 8'd1) begin
               frame_cmd = rx;
            end
            if ({1'b0, frame_pos} + 9'd1 < {1'b0, frame_len}) begin
               outcome   = '{1'b1, stxlsf_pkg::KIND_INFO, frame_pos, rx};
               frame_sum = frame_sum + rx;
               frame_pos = frame_pos + 8'd1;
            end else begin
               link_state = LINK_IDLE;
               if (rx == frame_sum) begin
                  outcome = '{1'b1, stxlsf_pkg::KIND_ACCEPT, 8'd0, frame_cmd};
               end else begin
                  outcome = '{1'b1, stxlsf_pkg::KIND_REJECT, 8'd0, nak_value};
               end
            end
         end
         default: begin
            link_state = (rx == open_byte) ? LINK_LENGTH : LINK_IDLE;
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      stxlsf_pkg::result_type predicted;
      stxlsf_pkg::result_type oldest;
      if (reset) begin
         link_state = LINK_IDLE;
         open_byte  = stxlsf_pkg::START_BYTE_RESET;
         nak_value  = stxlsf_pkg::NAK_BYTE_RESET;
         frame_len  = '0;
         frame_pos  = '0;
         frame_sum  = '0;
         frame_cmd  = '0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               stxlsf_pkg::CSR_START_BYTE: open_byte = csr_write_data;
               stxlsf_pkg::CSR_NAK_BYTE:   nak_value = csr_write_data;
               default:        ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected response kind %0d index %0d value %0d",
                  rsp_kind, rsp_byte_index, rsp_data_value));
            end else begin
               oldest = expected_results.pop_front();
               results_checked++;
               if (rsp_kind !== oldest.kind || rsp_byte_index !== oldest.byte_index ||
                   rsp_data_value !== oldest.data_value) begin
                  report_mismatch($sformatf(
                     "got kind %0d index %0d value %0d, want kind %0d index %0d value %0d",
                     rsp_kind, rsp_byte_index, rsp_data_value,
                     oldest.kind, oldest.byte_index, oldest.data_value));
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = decode_rx_byte(req_rx_byte);
            if (predicted.valid) begin
               expected_results.push_back(predicted);
            end
         end
         if (end_of_test && !leftovers_reported) begin
            leftovers_reported = 1'b1;
            if (expected_results.size() != 0) begin
               report_mismatch($sformatf("%0d expected responses never arrived",
                  expected_results.size()));
            end
         end
      end
      result_backlog = expected_results.size();
      frame_open     = (link_state != LINK_IDLE);
   end

endmodule

### verif/tb.sv
// Drives bytes and register writes into the frame receiver and reports the verdict.
module tb;

   logic                      clock;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   stxlsf_pkg::csr_index_type csr_index        = stxlsf_pkg::CSR_START_BYTE;
   logic [7:0]                csr_write_data   = 8'd0;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_rx_byte      = 8'd0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic [1:0]                rsp_kind;
   logic [7:0]                rsp_byte_index;
   logic [7:0]                rsp_data_value;
   logic                      end_of_test      = 1'b0;

   int            fault_count;
   int            result_backlog;
   int            results_checked;
   logic          frame_open;

   logic [1:0]    pace_sel      = 2'b11;
   logic [7:0]    cur_start     = stxlsf_pkg::START_BYTE_RESET;
   int            request_total = 0;
   int            framed_total  = 0;
   int            setting_count = 1;

   logic [7:0] opening [0:23] = '{
      8'hAA,
      8'h02, 8'h00,
      8'h02, 8'h01,
      8'h02, 8'h02, 8'h02,
      8'h02, 8'h02, 8'h05,
      8'h02, 8'h03, 8'hFF, 8'h02,
      8'h02, 8'h04, 8'h02, 8'h02, 8'h08,
      8'h02, 8'h03, 8'h00, 8'h00
   };

   stx_length_sum_frame_receiver_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_data_value   (rsp_data_value)
   );

   frame_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_data_value   (rsp_data_value),
      .end_of_test      (end_of_test),
      .fault_count      (fault_count),
      .result_backlog   (result_backlog),
      .results_checked  (results_checked),
      .frame_open       (frame_open)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : response_side
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = pace_sel[1] ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(input logic [7:0] rx);
      int gap;
      gap = pace_sel[0] ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      request_total++;
   endtask

   task automatic send_random_sequence;
      int         pick;
      int         len;
      int         body_count;
      int         pos;
      logic [7:0] sum;
      logic [7:0] info;
      if ($urandom_range(0, 15) == 0) begin
         pace_sel = 2'($urandom_range(0, 3));
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
         if (pick < 15) begin
            len = $urandom_range(0, 1);
         end else if (pick < 16) begin
            len = $urandom_range(100, 255);
         end else begin
            len = $urandom_range(2, 12);
         end
         send_byte(cur_start);
         send_byte(len[7:0]);
         framed_total += 2;
         if (len >= 2) begin
            body_count = (pick >= 88) ? $urandom_range(0, len - 2) : len - 1;
            sum = len[7:0];
            for (pos = 1; pos <= body_count; pos++) begin
               if (pos < len - 1) begin
                  info = 8'($urandom_range(0, 255));
                  sum  = sum + info;
                  send_byte(info);
               end else if ($urandom_range(0, 4) == 0) begin
                  send_byte(8'($urandom_range(0, 255)));
               end else begin
                  send_byte(sum);
               end
               framed_total++;
            end
         end
      end
   endtask

   task automatic settle;
      int wait_cycles;
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_open) begin
         send_byte(8'h00);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      wait_cycles = 0;
      while (result_backlog != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] opener, input logic [7:0] nak);
      csr_write_enable <= 1'b1;
      csr_index        <= stxlsf_pkg::CSR_START_BYTE;
      csr_write_data   <= opener;
      @(posedge clock);
      csr_index        <= stxlsf_pkg::CSR_NAK_BYTE;
      csr_write_data   <= nak;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_start = opener;
      setting_count++;
   endtask

   initial begin : stimulus
      int         phase_idx;
      int         quota;
      logic [7:0] opener;
      logic [7:0] nak;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (opening[i]) send_byte(opening[i]);
      for (phase_idx = 0; phase_idx < 7; phase_idx++) begin
         if (phase_idx > 0) begin
            settle();
            case (phase_idx)
               1: begin
                  opener = 8'h00;
                  nak    = 8'h00;
               end
               2: begin
                  opener = 8'hFF;
                  nak    = 8'hFF;
               end
               6: begin
                  opener = stxlsf_pkg::START_BYTE_RESET;
                  nak    = stxlsf_pkg::NAK_BYTE_RESET;
               end
               default: begin
                  opener = 8'($urandom_range(0, 255));
                  nak    = 8'($urandom_range(0, 255));
               end
            endcase
            load_settings(opener, nak);
         end
         quota = framed_total + 245;
         while (framed_total < quota) send_random_sequence();
      end
      settle();
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      $display("sent %0d requests, %0d of them framed, under %0d register settings",
         request_total, framed_total, setting_count);
      $display("compared %0d responses against prediction", results_checked);
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### stx_length_sum_frame_receiver_core.f
rtl/core/stxlsf_pkg.sv
rtl/core/stxlsf_parser.sv
rtl/core/stx_length_sum_frame_receiver_core.sv
verif/frame_result_checker.sv
verif/tb.sv
